### hdl/gbsw_pkg.sv
// Shared types and codes for the GIF block structure walker.
package gbsw_pkg;

  // Grammar position of the walker
  typedef enum logic [3:0] {
    PH_SIG_G,
    PH_SIG_I,
    PH_SIG_F,
    PH_HDR,
    PH_GFLAGS,
    PH_PRE_TOP,
    PH_TOP,
    PH_IMG_HDR,
    PH_IFLAGS,
    PH_PRE_SUB,
    PH_EXT_LBL,
    PH_SUB_LEN,
    PH_SUB_DATA,
    PH_DONE
  } phase_t;

  // Status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Byte codes of the grammar
  localparam logic [7:0] SIG_G_CHAR   = 8'h47;
  localparam logic [7:0] SIG_I_CHAR   = 8'h49;
  localparam logic [7:0] SIG_F_CHAR   = 8'h46;
  localparam logic [7:0] EXT_INTRO    = 8'h21;
  localparam logic [7:0] IMG_INTRO    = 8'h2C;
  localparam logic [7:0] TRAILER      = 8'h3B;
  localparam logic [7:0] COMMENT_LBL  = 8'hFE;
  localparam logic [7:0] TABLE_FLAG   = 8'h80;
  localparam logic [7:0] TABLE_SIZE_M = 8'h07;

  localparam int unsigned CNT_W = 10;

  // Fixed stretch lengths
  localparam logic [CNT_W-1:0] HDR_LEN     = 10'd7;
  localparam logic [CNT_W-1:0] IMG_HDR_LEN = 10'd8;

  // One result word
  typedef struct packed {
    logic [7:0] comment_byte;
    logic       comment_valid;
    logic [1:0] status;
  } result_t;

  // Color table length announced by a packed flags byte
  function automatic logic [CNT_W-1:0] table_len(input logic [7:0] flags);
    logic [2:0] n;
    n = flags[2:0] & TABLE_SIZE_M[2:0];
    if ((flags & TABLE_FLAG) == 8'h00) begin
      table_len = '0;
    end else begin
      table_len = (CNT_W'(3) << n) << 1;
    end
  endfunction

endpackage

### hdl/gbsw_parser.sv
// Grammar state machine and counters of the GIF block structure walker.
module gbsw_parser import gbsw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] data_byte,
  input  logic       last,
  output result_t    res
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] skip_count, skip_count_next;
  logic             in_comment, in_comment_next;
  logic             zero_seen_in_block, zero_seen_in_block_next;
  logic             sticky_error, sticky_error_next;

  logic [CNT_W-1:0] cnt_dec;
  logic             cnt_done;
  logic             emit;

  // Count-down of the current stretch
  assign cnt_dec  = (skip_count != '0) ? skip_count - 1'b1 : skip_count;
  assign cnt_done = (cnt_dec == '0);

  // Next state
  always_comb begin
    phase_next              = phase;
    skip_count_next         = skip_count;
    in_comment_next         = in_comment;
    zero_seen_in_block_next = zero_seen_in_block;
    sticky_error_next       = sticky_error;
    emit                    = 1'b0;
    if (!sticky_error) begin
      unique case (phase)
        PH_SIG_G: begin
          if (data_byte == SIG_G_CHAR) phase_next = PH_SIG_I;
          else sticky_error_next = 1'b1;
        end
        PH_SIG_I: begin
          if (data_byte == SIG_I_CHAR) phase_next = PH_SIG_F;
          else sticky_error_next = 1'b1;
        end
        PH_SIG_F: begin
          if (data_byte == SIG_F_CHAR) begin
            phase_next      = PH_HDR;
            skip_count_next = HDR_LEN;
          end else begin
            sticky_error_next = 1'b1;
          end
        end
        PH_HDR: begin
          skip_count_next = cnt_dec;
          if (cnt_done) phase_next = PH_GFLAGS;
        end
        PH_GFLAGS: begin
          skip_count_next = table_len(data_byte) + CNT_W'(2);
          phase_next      = PH_PRE_TOP;
        end
        PH_PRE_TOP: begin
          skip_count_next = cnt_dec;
          if (cnt_done) phase_next = PH_TOP;
        end
        PH_TOP: begin
          if (data_byte == EXT_INTRO) begin
            phase_next = PH_EXT_LBL;
          end else if (data_byte == IMG_INTRO) begin
            skip_count_next = IMG_HDR_LEN;
            phase_next      = PH_IMG_HDR;
          end else if (data_byte == TRAILER) begin
            phase_next = PH_DONE;
          end else begin
            sticky_error_next = 1'b1;
          end
        end
        PH_IMG_HDR: begin
          skip_count_next = cnt_dec;
          if (cnt_done) phase_next = PH_IFLAGS;
        end
        PH_IFLAGS: begin
          skip_count_next = table_len(data_byte) + CNT_W'(1);
          phase_next      = PH_PRE_SUB;
        end
        PH_PRE_SUB: begin
          skip_count_next = cnt_dec;
          if (cnt_done) begin
            in_comment_next = 1'b0;
            phase_next      = PH_SUB_LEN;
          end
        end
        PH_EXT_LBL: begin
          in_comment_next = (data_byte == COMMENT_LBL);
          phase_next      = PH_SUB_LEN;
        end
        PH_SUB_LEN: begin
          if (data_byte == 8'h00) begin
            in_comment_next = 1'b0;
            phase_next      = PH_TOP;
          end else begin
            skip_count_next         = CNT_W'(data_byte);
            zero_seen_in_block_next = 1'b0;
            phase_next              = PH_SUB_DATA;
          end
        end
        PH_SUB_DATA: begin
          // text ends at a zero byte for the rest of the sub-block
          if (in_comment && !zero_seen_in_block) begin
            if (data_byte == 8'h00) zero_seen_in_block_next = 1'b1;
            else emit = 1'b1;
          end
          skip_count_next = cnt_dec;
          if (cnt_done) phase_next = PH_SUB_LEN;
        end
        PH_DONE: begin
        end
        default: begin
          sticky_error_next = 1'b1;
        end
      endcase
      // truncated stream
      if (last && phase_next != PH_DONE) sticky_error_next = 1'b1;
    end
  end

  // Result word for this byte
  always_comb begin
    if (sticky_error_next) begin
      res.comment_byte  = 8'h00;
      res.comment_valid = 1'b0;
      res.status        = ST_ERR;
    end else begin
      res.comment_byte  = emit ? data_byte : 8'h00;
      res.comment_valid = emit;
      res.status        = (phase_next == PH_DONE) ? ST_OK : ST_BUSY;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SIG_G;
      skip_count         <= '0;
      in_comment         <= 1'b0;
      zero_seen_in_block <= 1'b0;
      sticky_error       <= 1'b0;
    end else if (en) begin
      phase              <= phase_next;
      skip_count         <= skip_count_next;
      in_comment         <= in_comment_next;
      zero_seen_in_block <= zero_seen_in_block_next;
      sticky_error       <= sticky_error_next;
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    sticky_error |=> sticky_error)
    else $error("structure error cleared without reset");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !sticky_error) |=> (phase == PH_DONE && !sticky_error))
    else $error("left trailer state");

  a_text_in_comment: assert property (@(posedge clk) disable iff (rst)
    res.comment_valid |-> (in_comment && phase == PH_SUB_DATA && !zero_seen_in_block))
    else $error("text word outside comment sub-block");
`endif

endmodule

### hdl/gif_block_structure_walker.sv
// Top level of the GIF block structure walker: input register, parser, result register.
// A word accepted into the input register is parsed and then held in the result register.
// Throughput: one word per cycle while result_stall does not hold a waiting word.
// While a finished word waits in the result register under stall, the input register can take one word.
// Reset (rst, synchronous) empties both registers and returns the parser to the
// signature check with counters, comment flags and error cleared.
module gif_block_structure_walker import gbsw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] comment_byte,
  output logic       comment_valid,
  output logic [1:0] status
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       adv;
  result_t    res;
  result_t    res_reg;

  // Pipeline control
  assign adv        = s1_valid && (!result_valid || !result_stall);
  assign data_stall = s1_valid && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!data_stall) begin
      s1_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!data_stall) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  gbsw_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .data_byte (s1_byte),
    .last      (s1_last),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_reg <= res;
  end

  assign comment_byte  = res_reg.comment_byte;
  assign comment_valid = res_reg.comment_valid;
  assign status        = res_reg.status;

endmodule
